// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Short forms for the concurrent assertions used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define PTD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ptdms_pkg.sv =====
// ----------------------------------------------------------------------------
// ptdms_pkg
// Shared widths, constants and unit response types of the decayed moving sum.
// ----------------------------------------------------------------------------
`default_nettype none

package ptdms_pkg;

    localparam int TIME_W     = 31;
    localparam int SAMPLE_W   = 32;
    localparam int SUM_W      = 48;
    localparam int HL_W       = 20;
    localparam int FACTOR_W   = 32;
    localparam int PW_W       = 8;
    localparam int DIVR_W     = 9;   // divisor: page width or decay length (up to 511)
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DECAY_LENGTH    = 20;
    localparam int MIN_PAGE_MS     = 10;
    localparam int MAX_PAGE_MS     = 200;

    localparam logic [HL_W-1:0]     RST_HALF_LIFE    = 20'd1000;
    localparam logic [FACTOR_W-1:0] RST_DECAY_FACTOR = 32'd4080218931;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_LIFE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR = 2'd1;

    localparam logic signed [SUM_W-1:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 48'sh8000_0000_0000;

    // radix-16 divider: four quotient bits per cycle over the 31-bit dividend zero-extended to 32 bits
    localparam int DIV_STEPS  = 4;
    localparam int DIV_CYCLES = 8;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [TIME_W-1:0]   quotient;
        logic [DIVR_W-1:0]   remainder;
    } t_div_rsp;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [SUM_W-1:0]    result;
    } t_scale_rsp;

endpackage

`default_nettype wire

// ===== hw/rtl/paged_time_decay_moving_sum.sv =====
// ----------------------------------------------------------------------------
// paged_time_decay_moving_sum
// Time-decayed moving sum of timestamped samples over fixed-width pages.
// ----------------------------------------------------------------------------
// Input beats (time_ms, sample_value) arrive on i_in_valid/o_in_ready; one
// result beat (decayed_sum, restarted) leaves on o_out_valid/i_out_ready for
// each input beat. Register writes use i_cfg_valid/o_cfg_ready with index 0
// for the half life and index 1 for the per-page decay factor.
// One item at a time. Each division by the page width runs in the radix-16
// divider: one of the time on the first sample, one of the gap since the
// page start otherwise, and a second one of the time on a gap restart. A
// decay adds a RAM read and the split multiply. The next beat can be taken as
// soon as the result sits in the output register, even while the receiver
// stalls; a stalled output only holds the block after the following item
// is done.
// After reset, and after every write to index 0 or 1, the page width and
// table length are derived (two divisions) and the decay power table is
// rebuilt. Input and config ready stay low during that time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module paged_time_decay_moving_sum #(
    parameter int TABLE_DEPTH = ptdms_pkg::DEF_TABLE_DEPTH
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,

    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [ptdms_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [ptdms_pkg::CFG_DATA_W-1:0]      i_cfg_data,

    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic [ptdms_pkg::TIME_W-1:0]          i_time_ms,
    input  wire logic signed [ptdms_pkg::SAMPLE_W-1:0] i_sample_value,

    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic signed [ptdms_pkg::SUM_W-1:0]         o_decayed_sum,
    output logic                                       o_restarted
);

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int LW  = $clog2(TABLE_DEPTH + 1);
    localparam int TW  = ptdms_pkg::TIME_W;
    localparam int SW  = ptdms_pkg::SUM_W;
    localparam int XW  = ptdms_pkg::SAMPLE_W;
    localparam int FW  = ptdms_pkg::FACTOR_W;
    localparam int DW  = ptdms_pkg::DIVR_W;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_CF_START = 4'd1;
    localparam logic [3:0] ST_CF_PW    = 4'd2;
    localparam logic [3:0] ST_CF_FADE  = 4'd3;
    localparam logic [3:0] ST_CF_TAB   = 4'd4;
    localparam logic [3:0] ST_DIV_GAP  = 4'd5;
    localparam logic [3:0] ST_DIV_T    = 4'd6;
    localparam logic [3:0] ST_RD       = 4'd7;
    localparam logic [3:0] ST_SCALE    = 4'd8;
    localparam logic [3:0] ST_OUT      = 4'd9;

    logic [3:0]                       r_state, n_state;
    logic [ptdms_pkg::HL_W-1:0]       r_hl, n_hl;
    logic [FW-1:0]                    r_factor, n_factor;
    logic [ptdms_pkg::PW_W-1:0]       r_pw, n_pw;
    logic [LW-1:0]                    r_len, n_len;
    logic [LW-1:0]                    r_idx, n_idx;
    logic                             r_started, n_started;
    logic signed [SW-1:0]             r_sum, n_sum;
    logic [TW-1:0]                    r_ps, n_ps;
    logic [TW-1:0]                    r_t, n_t;
    logic signed [XW-1:0]             r_sample, n_sample;
    logic                             r_back, n_back;
    logic                             r_restart, n_restart;
    logic                             r_out_valid, n_out_valid;
    logic signed [SW-1:0]             r_out_sum;
    logic                             r_out_restart;
    logic                             out_load;

    // shared units
    logic                             div_start;
    logic [TW-1:0]                    div_dividend;
    logic [DW-1:0]                    div_divisor;
    ptdms_pkg::t_div_rsp              div_rsp;
    logic                             scale_start;
    logic [SW-1:0]                    scale_mag;
    logic [FW-1:0]                    scale_factor;
    ptdms_pkg::t_scale_rsp            scale_rsp;

    logic                             ram_we;
    logic [AW-1:0]                    ram_waddr;
    logic [FW-1:0]                    ram_wdata;
    logic                             ram_re;
    logic [AW-1:0]                    ram_raddr;
    logic [FW-1:0]                    ram_rdata;

    // derived values
    logic [TW-1:0]                    pw_lo;
    logic [ptdms_pkg::PW_W-1:0]       pw_calc;
    logic [TW-1:0]                    fade;
    logic [TW:0]                      fade2;
    logic [LW-1:0]                    len_calc;
    logic [SW-1:0]                    sum_mag;
    logic signed [SW-1:0]             decayed;
    logic signed [SW-1:0]             add_base;
    logic signed [SW:0]               sum_ext;
    logic signed [SW-1:0]             sum_sat;

    // page width clamp, low bound first
    assign pw_lo   = (div_rsp.quotient < TW'(ptdms_pkg::MIN_PAGE_MS)) ?
                     TW'(ptdms_pkg::MIN_PAGE_MS) : div_rsp.quotient;
    assign pw_calc = (pw_lo > TW'(ptdms_pkg::MAX_PAGE_MS)) ?
                     ptdms_pkg::PW_W'(ptdms_pkg::MAX_PAGE_MS) : pw_lo[ptdms_pkg::PW_W-1:0];

    assign fade     = (div_rsp.quotient == '0) ? TW'(1) : div_rsp.quotient;
    assign fade2    = {fade, 1'b0};
    assign len_calc = (fade2 >= (TW+1)'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH) : fade2[LW-1:0];

    assign sum_mag  = r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);
    assign decayed  = r_sum[SW-1] ? -$signed(scale_rsp.result) : $signed(scale_rsp.result);
    assign add_base = (r_state == ST_SCALE) ? decayed : r_sum;
    assign sum_ext  = {add_base[SW-1], add_base} + (SW+1)'(r_sample);
    assign sum_sat  = (sum_ext[SW] != sum_ext[SW-1]) ?
                      (sum_ext[SW] ? ptdms_pkg::SUM_MIN : ptdms_pkg::SUM_MAX) :
                      sum_ext[SW-1:0];

    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_in_ready  = (r_state == ST_IDLE) && !i_cfg_valid;
    assign out_load    = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state      = r_state;
        n_hl         = r_hl;
        n_factor     = r_factor;
        n_pw         = r_pw;
        n_len        = r_len;
        n_idx        = r_idx;
        n_started    = r_started;
        n_sum        = r_sum;
        n_ps         = r_ps;
        n_t          = r_t;
        n_sample     = r_sample;
        n_back       = r_back;
        n_restart    = r_restart;
        n_out_valid  = r_out_valid && !i_out_ready;

        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = {1'b0, r_pw};
        scale_start  = 1'b0;
        scale_mag    = sum_mag;
        scale_factor = ram_rdata;
        ram_we       = 1'b0;
        ram_waddr    = r_idx[AW-1:0];
        ram_wdata    = scale_rsp.result[FW-1:0];
        ram_re       = 1'b0;
        ram_raddr    = div_rsp.quotient[AW-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (i_cfg_valid) begin
                    unique case (i_cfg_index)
                        ptdms_pkg::CFG_HALF_LIFE: begin
                            n_hl    = i_cfg_data[ptdms_pkg::HL_W-1:0];
                            n_state = ST_CF_START;
                        end
                        ptdms_pkg::CFG_DECAY_FACTOR: begin
                            n_factor = i_cfg_data[FW-1:0];
                            n_state  = ST_CF_START;
                        end
                        default: ;
                    endcase
                end else if (i_in_valid) begin
                    n_t       = i_time_ms;
                    n_sample  = i_sample_value;
                    div_start = 1'b1;
                    if (!r_started) begin
                        div_dividend = i_time_ms;
                        n_state      = ST_DIV_T;
                    end else begin
                        // time before the page start counts as zero pages
                        n_back       = (i_time_ms < r_ps);
                        div_dividend = (i_time_ms < r_ps) ? '0 : TW'(i_time_ms - r_ps);
                        n_state      = ST_DIV_GAP;
                    end
                end
            end
            ST_CF_START: begin
                div_start    = 1'b1;
                div_dividend = TW'(r_hl);
                div_divisor  = DW'(ptdms_pkg::DECAY_LENGTH);
                n_state      = ST_CF_PW;
            end
            ST_CF_PW: begin
                if (div_rsp.done) begin
                    n_pw         = pw_calc;
                    div_start    = 1'b1;
                    div_dividend = TW'(r_hl);
                    div_divisor  = {1'b0, pw_calc};
                    n_state      = ST_CF_FADE;
                end
            end
            ST_CF_FADE: begin
                if (div_rsp.done) begin
                    n_len     = len_calc;
                    ram_we    = 1'b1;
                    ram_waddr = AW'(1);
                    ram_wdata = r_factor;
                    n_idx     = LW'(2);
                    if (len_calc > LW'(2)) begin
                        scale_start  = 1'b1;
                        scale_mag    = SW'(r_factor);
                        scale_factor = r_factor;
                        n_state      = ST_CF_TAB;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_CF_TAB: begin
                // each power feeds the next multiply straight from the unit
                if (scale_rsp.done) begin
                    ram_we = 1'b1;
                    if ((LW+1)'(r_idx) + (LW+1)'(1) < (LW+1)'(r_len)) begin
                        n_idx        = r_idx + 1'b1;
                        scale_start  = 1'b1;
                        scale_mag    = SW'(scale_rsp.result[FW-1:0]);
                        scale_factor = r_factor;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_DIV_GAP: begin
                if (div_rsp.done) begin
                    if (div_rsp.quotient >= TW'(r_len)) begin
                        div_start    = 1'b1;
                        div_dividend = r_t;
                        n_state      = ST_DIV_T;
                    end else begin
                        n_restart = 1'b0;
                        n_ps      = r_back ? r_ps : TW'(r_t - TW'(div_rsp.remainder));
                        if (div_rsp.quotient == '0) begin
                            n_sum   = sum_sat;
                            n_state = ST_OUT;
                        end else begin
                            ram_re  = 1'b1;
                            n_state = ST_RD;
                        end
                    end
                end
            end
            ST_DIV_T: begin
                if (div_rsp.done) begin
                    n_sum     = SW'(r_sample);
                    n_ps      = TW'(r_t - TW'(div_rsp.remainder));
                    n_started = 1'b1;
                    n_restart = 1'b1;
                    n_state   = ST_OUT;
                end
            end
            ST_RD: begin
                scale_start = 1'b1;
                n_state     = ST_SCALE;
            end
            ST_SCALE: begin
                if (scale_rsp.done) begin
                    n_sum   = sum_sat;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CF_START;
            r_hl        <= ptdms_pkg::RST_HALF_LIFE;
            r_factor    <= ptdms_pkg::RST_DECAY_FACTOR;
            r_pw        <= '0;
            r_len       <= '0;
            r_idx       <= '0;
            r_started   <= 1'b0;
            r_sum       <= '0;
            r_ps        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hl        <= n_hl;
            r_factor    <= n_factor;
            r_pw        <= n_pw;
            r_len       <= n_len;
            r_idx       <= n_idx;
            r_started   <= n_started;
            r_sum       <= n_sum;
            r_ps        <= n_ps;
            r_out_valid <= n_out_valid;
        end
        r_t       <= n_t;
        r_sample  <= n_sample;
        r_back    <= n_back;
        r_restart <= n_restart;
        if (out_load) begin
            r_out_sum     <= r_sum;
            r_out_restart <= r_restart;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_decayed_sum = r_out_sum;
    assign o_restarted   = r_out_restart;

    ptdms_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_rsp      (div_rsp)
    );

    ptdms_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (scale_start),
        .i_mag    (scale_mag),
        .i_factor (scale_factor),
        .o_rsp    (scale_rsp)
    );

    ptdms_ram #(
        .WIDTH (FW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    `PTD_ASSERT_IMP(a_div_free, i_clk, i_rst_n, div_start, !div_rsp.busy, "divider restarted while busy")
    `PTD_ASSERT_IMP(a_scale_free, i_clk, i_rst_n, scale_start, !scale_rsp.busy, "multiply restarted while busy")
    `PTD_ASSERT_IMP(a_rd_range, i_clk, i_rst_n, ram_re, (ram_raddr != '0) && (LW'(ram_raddr) < r_len), "table read outside built range")
    `PTD_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready && !o_cfg_ready, "beat taken while an item is in progress")

endmodule

`default_nettype wire

// ===== hw/rtl/ptdms_ram.sv =====
// ----------------------------------------------------------------------------
// ptdms_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ptdms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hw/rtl/ptdms_div.sv =====
// ----------------------------------------------------------------------------
// ptdms_div
// Iterative unsigned divider, 31-bit dividend by 9-bit divisor, radix 16.
// ----------------------------------------------------------------------------
`default_nettype none

module ptdms_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [ptdms_pkg::TIME_W-1:0]  i_dividend,
    input  wire logic [ptdms_pkg::DIVR_W-1:0]  i_divisor,
    output ptdms_pkg::t_div_rsp                o_rsp
);

    localparam int QW = ptdms_pkg::TIME_W + 1;
    localparam int CW = $clog2(ptdms_pkg::DIV_CYCLES);
    localparam int RW = ptdms_pkg::DIVR_W;

    logic          r_run, n_run;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [QW-1:0] r_quo, n_quo;
    logic [RW-1:0] r_rem, n_rem;
    logic [RW-1:0] r_div, n_div;

    logic [QW-1:0] step_quo;
    logic [RW-1:0] step_rem;
    logic [RW:0]   step_ext;

    // four restoring steps per cycle, remainder stays below the divisor
    always_comb begin
        step_rem = r_rem;
        step_quo = r_quo;
        step_ext = '0;
        for (int k = 0; k < ptdms_pkg::DIV_STEPS; k++) begin
            step_ext = {step_rem, step_quo[QW-1]};
            step_quo = {step_quo[QW-2:0], 1'b0};
            if (step_ext >= {1'b0, r_div}) begin
                step_rem    = RW'(step_ext - {1'b0, r_div});
                step_quo[0] = 1'b1;
            end else begin
                step_rem = step_ext[RW-1:0];
            end
        end
    end

    always_comb begin
        n_run  = r_run;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_run = 1'b1;
            n_cnt = '0;
            n_quo = {1'b0, i_dividend};
            n_rem = '0;
            n_div = i_divisor;
        end else if (r_run) begin
            n_quo = step_quo;
            n_rem = step_rem;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(ptdms_pkg::DIV_CYCLES - 1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_rsp.busy      = r_run;
    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo[ptdms_pkg::TIME_W-1:0];
    assign o_rsp.remainder = r_rem;

endmodule

`default_nettype wire

// ===== hw/rtl/ptdms_scale.sv =====
// ----------------------------------------------------------------------------
// ptdms_scale
// round(mag * factor / 2^32), half up, for a 48-bit magnitude and Q0.32
// factor; one 24x32 multiplier used for the low then the high half.
// ----------------------------------------------------------------------------
`default_nettype none

module ptdms_scale (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [ptdms_pkg::SUM_W-1:0]     i_mag,
    input  wire logic [ptdms_pkg::FACTOR_W-1:0]  i_factor,
    output ptdms_pkg::t_scale_rsp                o_rsp
);

    localparam int HW = ptdms_pkg::SUM_W / 2;
    localparam int FW = ptdms_pkg::FACTOR_W;
    localparam int PW = HW + FW;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LO   = 2'd1;
    localparam logic [1:0] PH_HI   = 2'd2;
    localparam logic [1:0] PH_SUM  = 2'd3;

    logic [1:0]                   r_phase, n_phase;
    logic                         r_done, n_done;
    logic [HW-1:0]                r_hi, r_lo;
    logic [FW-1:0]                r_f;
    logic [PW:0]                  r_b;
    logic [PW-1:0]                r_a;
    logic [ptdms_pkg::SUM_W-1:0]  r_res;

    logic [HW-1:0]                mul_op;
    logic [PW-1:0]                mul_p;
    logic [PW+1:0]                low_sum;

    assign mul_op  = (r_phase == PH_LO) ? r_lo : r_hi;
    assign mul_p   = PW'(mul_op) * PW'(r_f);
    assign low_sum = (PW+2)'({r_a[7:0], 24'd0}) + (PW+2)'(r_b);

    always_comb begin
        n_phase = r_phase;
        n_done  = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_start) begin
                    n_phase = PH_LO;
                end
            end
            PH_LO:  n_phase = PH_HI;
            PH_HI:  n_phase = PH_SUM;
            PH_SUM: begin
                n_phase = PH_IDLE;
                n_done  = 1'b1;
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
        end
        if (r_phase == PH_IDLE && i_start) begin
            r_hi <= i_mag[ptdms_pkg::SUM_W-1:HW];
            r_lo <= i_mag[HW-1:0];
            r_f  <= i_factor;
        end
        if (r_phase == PH_LO) begin
            r_b <= (PW+1)'(mul_p) + (PW+1)'(33'h0_8000_0000);
        end
        if (r_phase == PH_HI) begin
            r_a <= mul_p;
        end
        if (r_phase == PH_SUM) begin
            r_res <= ptdms_pkg::SUM_W'(r_a >> 8) + ptdms_pkg::SUM_W'(low_sum[PW+1:32]);
        end
    end

    assign o_rsp.busy   = (r_phase != PH_IDLE);
    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

endmodule

`default_nettype wire
